// ===== design/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Types, codes and constants shared by the ARP responder and cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int unsigned DEFAULT_CACHE_ENTRIES = 16;
    localparam int unsigned CFG_DATA_W = 48;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [31:0] RESET_SUBNET_MASK = 32'hFFFF_FF00;
    localparam logic [15:0] RESET_LIFETIME = 16'd60;

    localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] HTYPE_ETH = 16'h0001;
    localparam logic [7:0] HLEN_ETH = 8'd6;
    localparam logic [7:0] PLEN_IPV4 = 8'd4;
    localparam logic [15:0] ARP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_REPLY = 16'd2;

    typedef enum logic [1:0] {
        REG_LOCAL_IP = 2'd0,
        REG_LOCAL_MAC = 2'd1,
        REG_SUBNET_MASK = 2'd2,
        REG_LIFETIME = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_PACKET = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_REPLY = 2'd1,
        ACT_BCAST = 2'd2,
        ACT_HIT = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_OK = 4'd0,
        ST_SHORT = 4'd1,
        ST_BAD_PTYPE = 4'd2,
        ST_BAD_HTYPE = 4'd3,
        ST_BAD_LEN = 4'd4,
        ST_NO_ROUTE = 4'd5,
        ST_NOT_MINE = 4'd6,
        ST_BAD_OPCODE = 4'd7,
        ST_DUPLICATE = 4'd8,
        ST_FULL = 4'd9,
        ST_CACHED = 4'd10
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } ctrl_state_t;

    // Kind of work the datapath does per scanned entry.
    typedef enum logic [1:0] {
        SCAN_FIND,
        SCAN_INSERT,
        SCAN_AGE
    } scan_kind_t;

    typedef struct packed {
        logic [1:0] op;
        logic frame_long_enough;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0] hw_len;
        logic [7:0] proto_len;
        logic [15:0] arp_opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [31:0] query_ip;
    } arp_in_t;

    typedef struct packed {
        logic [1:0] action;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
        logic [3:0] status;
    } arp_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic finish;
    } arpc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } arpc_stat_t;

endpackage

// ===== design/arpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// arpc_ctrl
// Controller: accepts a word, steps the datapath through its entry scan and
// issues the result strobe.
// ----------------------------------------------------------------------------
module arpc_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  arpc_pkg::arpc_stat_t stat,
    output arpc_pkg::arpc_cmd_t cmd
);
    import arpc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.need_scan)
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !busy)
        else $error("controller did not return to idle after a result");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy)
        else $error("item loaded while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load, cmd.scan_step, cmd.finish}) <= 1)
        else $error("more than one datapath command at once");

endmodule

// ===== design/arpc_datapath.sv =====
// ----------------------------------------------------------------------------
// arpc_datapath
// Datapath: configuration registers, header checks, the entry cache and the
// one-entry-per-cycle scan for lookup, insertion and aging.
// ----------------------------------------------------------------------------
module arpc_datapath #(
    parameter int unsigned CACHE_ENTRIES = arpc_pkg::DEFAULT_CACHE_ENTRIES
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  arpc_pkg::arp_in_t in_word,
    input  arpc_pkg::arpc_cmd_t cmd,
    output arpc_pkg::arpc_stat_t stat,
    output logic done,
    output arpc_pkg::arp_out_t result
);
    import arpc_pkg::*;

    localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    logic [31:0] local_ip_reg;
    logic [47:0] local_mac_reg;
    logic [31:0] mask_reg;
    logic [15:0] lifetime_reg;

    logic [CACHE_ENTRIES-1:0] valid_reg;
    logic [31:0] ip_mem [CACHE_ENTRIES];
    logic [47:0] mac_mem [CACHE_ENTRIES];
    logic [15:0] ticks_mem [CACHE_ENTRIES];

    scan_kind_t kind_reg;
    logic scan_reg;
    logic [IDX_W-1:0] idx_reg;
    logic found_reg;
    logic [47:0] mac_reg;
    logic [31:0] key_reg;
    logic [47:0] smac_reg;
    arp_out_t res_reg;
    logic done_reg;

    // The local MAC is stored in a configuration register but is not used or output by this block.
    logic mac_cfg_unused;
    assign mac_cfg_unused = ^local_mac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= '0;
            local_mac_reg <= '0;
            mask_reg <= RESET_SUBNET_MASK;
            lifetime_reg <= RESET_LIFETIME;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_LOCAL_IP: local_ip_reg <= cfg_data[31:0];
                REG_LOCAL_MAC: local_mac_reg <= cfg_data;
                REG_SUBNET_MASK: mask_reg <= cfg_data[31:0];
                REG_LIFETIME: lifetime_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    function automatic logic routable(input logic [31:0] a, input logic [31:0] m,
                                      input logic [31:0] l);
        return (a & m) == (l & m);
    endfunction

    // Decode of the incoming word at load time.
    arp_out_t early;
    logic early_scan;
    scan_kind_t early_kind;
    logic [31:0] early_key;
    always_comb
    begin
        early = '0;
        early_scan = 1'b0;
        early_kind = SCAN_FIND;
        early_key = in_word.query_ip;
        case (op_t'(in_word.op))
            OP_PACKET:
            begin
                early_key = in_word.sender_ip;
                if (!in_word.frame_long_enough) early.status = ST_SHORT;
                else if (in_word.proto_type != PTYPE_IPV4) early.status = ST_BAD_PTYPE;
                else if (in_word.hw_type != HTYPE_ETH) early.status = ST_BAD_HTYPE;
                else if (in_word.hw_len != HLEN_ETH || in_word.proto_len != PLEN_IPV4)
                    early.status = ST_BAD_LEN;
                else if (!routable(in_word.target_ip, mask_reg, local_ip_reg))
                    early.status = ST_NO_ROUTE;
                else if (in_word.target_ip != local_ip_reg) early.status = ST_NOT_MINE;
                else if (in_word.arp_opcode == ARP_REQUEST)
                begin
                    if (!routable(in_word.sender_ip, mask_reg, local_ip_reg))
                        early.status = ST_NO_ROUTE;
                    else
                    begin
                        early.action = ACT_REPLY;
                        early.peer_mac = in_word.sender_mac;
                        early.peer_ip = in_word.sender_ip;
                    end
                end
                else if (in_word.arp_opcode == ARP_REPLY)
                begin
                    if (!routable(in_word.sender_ip, mask_reg, local_ip_reg))
                        early.status = ST_NO_ROUTE;
                    else
                    begin
                        early_scan = 1'b1;
                        early_kind = SCAN_INSERT;
                    end
                end
                else early.status = ST_BAD_OPCODE;
            end
            OP_LOOKUP:
            begin
                if (!routable(in_word.query_ip, mask_reg, local_ip_reg))
                    early.status = ST_NO_ROUTE;
                else
                begin
                    early_scan = 1'b1;
                    early_kind = SCAN_FIND;
                end
            end
            OP_TICK:
            begin
                early_scan = 1'b1;
                early_kind = SCAN_AGE;
            end
            default: ;
        endcase
    end

    logic hit_now;
    assign hit_now = valid_reg[idx_reg] && (ip_mem[idx_reg] == key_reg);

    logic [15:0] dec_ticks;
    assign dec_ticks = (ticks_mem[idx_reg] != 16'd0) ? ticks_mem[idx_reg] - 16'd1 : 16'd0;

    // Insertion goes into the lowest free slot, found during the same scan
    // that looks for a duplicate.
    logic lookup_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic free_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            scan_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            lookup_reg <= 1'b0;
            kind_reg <= SCAN_FIND;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.load)
            begin
                scan_reg <= early_scan;
                kind_reg <= early_kind;
                key_reg <= early_key;
                smac_reg <= in_word.sender_mac;
                res_reg <= early;
                idx_reg <= '0;
                found_reg <= 1'b0;
                free_found_reg <= 1'b0;
                lookup_reg <= early_scan && (early_kind == SCAN_FIND);
                mac_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                case (kind_reg)
                    SCAN_FIND:
                    begin
                        if (hit_now && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            mac_reg <= mac_mem[idx_reg];
                        end
                    end
                    SCAN_INSERT:
                    begin
                        if (hit_now) found_reg <= 1'b1;
                        if (!valid_reg[idx_reg] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg <= idx_reg;
                        end
                    end
                    SCAN_AGE:
                    begin
                        if (valid_reg[idx_reg])
                        begin
                            if (dec_ticks == 16'd0) valid_reg[idx_reg] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
                if (idx_reg == LAST_IDX) scan_reg <= 1'b0;
                else idx_reg <= idx_reg + IDX_W'(1);
            end
            else if (cmd.finish)
            begin
                if (kind_reg == SCAN_INSERT && res_reg.status == ST_OK &&
                    res_reg.action == ACT_NONE)
                begin
                    if (found_reg) res_reg.status <= ST_DUPLICATE;
                    else if (!free_found_reg) res_reg.status <= ST_FULL;
                    else
                    begin
                        res_reg.status <= ST_CACHED;
                        valid_reg[free_idx_reg] <= 1'b1;
                    end
                end
                else if (kind_reg == SCAN_FIND && res_reg.status == ST_OK &&
                         res_reg.action == ACT_NONE && lookup_reg)
                begin
                    res_reg.peer_ip <= key_reg;
                    if (found_reg)
                    begin
                        res_reg.action <= ACT_HIT;
                        res_reg.peer_mac <= mac_reg;
                    end
                    else res_reg.action <= ACT_BCAST;
                end
            end
        end
    end

    // Entry payload storage; no reset.
    logic ins_fire;
    assign ins_fire = cmd.finish && kind_reg == SCAN_INSERT && res_reg.status == ST_OK &&
                      res_reg.action == ACT_NONE && !found_reg && free_found_reg;

    always_ff @(posedge clk)
    begin
        if (ins_fire)
        begin
            ip_mem[free_idx_reg] <= key_reg;
            mac_mem[free_idx_reg] <= smac_reg;
            ticks_mem[free_idx_reg] <= lifetime_reg;
        end
        else if (cmd.scan_step && kind_reg == SCAN_AGE && valid_reg[idx_reg])
        begin
            ticks_mem[idx_reg] <= dec_ticks;
        end
    end

    // Items with no scan, or a tick, are final as loaded; the action of a loaded
    // lookup and the "ok" status of a loaded insert stay provisional until the scan ends.
    assign stat.need_scan = scan_reg;
    assign stat.scan_last = (idx_reg == LAST_IDX);
    assign done = done_reg;
    assign result = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> scan_reg)
        else $error("scan step with no scan pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (res_reg.action != ACT_NONE ||
                  (res_reg.peer_mac == '0 && res_reg.peer_ip == '0)))
        else $error("no-action result carries an address");
    assert property (@(posedge clk) disable iff (!rst_n)
        ins_fire |-> !valid_reg[free_idx_reg])
        else $error("insertion into an occupied slot");

endmodule

// ===== design/arp_responder_cache_unit.sv =====
// ----------------------------------------------------------------------------
// arp_responder_cache_unit
// ARP responder with a small aging address cache for one interface.
//
// Channel   Dir  Handshake           Payload
// cfg       in   cfg_we              cfg_idx, cfg_data
// item      in   start && !busy      in_word (arp_in_t)
// result    out  result_valid        result (arp_out_t)
//
// An item scans the cache when it is a lookup, a valid reply or a tick, and
// skips the scan otherwise; the scan reads one entry a cycle.
// The result strobe rises in the cycle after the controller finishes; busy drops
// in the same cycle, so the next word may be started then.
// Reset clears all entry valid bits at once; no clearing pass is needed.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module arp_responder_cache_unit #(
    parameter int unsigned CACHE_ENTRIES = arpc_pkg::DEFAULT_CACHE_ENTRIES
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic start,
    output logic busy,
    input  arpc_pkg::arp_in_t in_word,
    output logic result_valid,
    output arpc_pkg::arp_out_t result
);
    import arpc_pkg::*;

    arpc_cmd_t cmd;
    arpc_stat_t stat;

    arpc_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .stat(stat),
        .cmd(cmd)
    );

    arpc_datapath #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_data(cfg_data),
        .in_word(in_word),
        .cmd(cmd),
        .stat(stat),
        .done(result_valid),
        .result(result)
    );

endmodule
